>>> sv/ssee_pkg.sv
// Package with shared constants for the shadow silhouette edge extruder.
`default_nettype none

package ssee_pkg;

   localparam int COORD_BITS_DEFAULT  = 32;
   localparam int NORMAL_BITS_DEFAULT = 16;
   localparam int OUT_BITS            = 48;
   localparam int FACTOR_BITS         = 16;
   localparam int QUAD_VERTS          = 4;

   localparam longint LIGHT_X_RESET = 0;
   localparam longint LIGHT_Y_RESET = 32768000;
   localparam longint LIGHT_Z_RESET = 0;
   localparam logic [FACTOR_BITS-1:0] FACTOR_RESET = 16'd10000;

   localparam logic [1:0] REG_LIGHT_X = 2'd0;
   localparam logic [1:0] REG_LIGHT_Y = 2'd1;
   localparam logic [1:0] REG_LIGHT_Z = 2'd2;
   localparam logic [1:0] REG_FACTOR  = 2'd3;

   typedef logic signed [OUT_BITS-1:0] vert_coord_type;

endpackage

`default_nettype wire

>>> sv/shadow_silhouette_edge_extruder_unit.sv
// Top level of the shadow silhouette edge extruder: edge test and quad extrusion pipeline.
//
// One input word carries a mesh edge: endpoints A and B and the normals of the two faces
// that share it. The light position and the extrusion factor are set through the csr port
// while the block is idle; the user is bound by this, the block does not enforce it. Each
// edge goes through three pipeline stages: the doubled light-to-midpoint vector and endpoint
// offsets, then the six dot-product terms and six extrusion products, then the dot sums and
// the saturated extruded coordinates. A silhouette edge is loaded into a four-vertex output
// buffer and leaves as four result words V1, V2, V2 extruded, V1 extruded, with tlast on the
// fourth; other edges leave no result. The output buffer sends one word a cycle while
// rsp_tready is high, and loads the next silhouette quad as the last word of the current one
// is taken; edges that are not silhouettes pass at one per cycle while nothing stalls. When
// the receiver stalls, the buffer holds its word and the pipeline stages fill up behind it
// before req_tready drops; nothing is lost or repeated. Reset empties all stages and the
// buffer and loads the default light position (0, 500.0, 0) and extrusion factor 10000.
`default_nettype none

module shadow_silhouette_edge_extruder_unit #(
   parameter int COORD_BITS  = ssee_pkg::COORD_BITS_DEFAULT,
   parameter int NORMAL_BITS = ssee_pkg::NORMAL_BITS_DEFAULT,
   localparam int IN_BITS    = 6 * COORD_BITS + 6 * NORMAL_BITS,
   localparam int IN_WIDTH   = ((IN_BITS + 7) / 8) * 8,
   localparam int CSR_BITS   = (COORD_BITS > 32) ? 64 : 32,
   localparam int ADDR_LSB   = (COORD_BITS > 32) ? 3 : 2,
   localparam int ADDR_BITS  = ADDR_LSB + 2
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // a_x, a_y, a_z, b_x, b_y, b_z, face_one_nx/ny/nz, face_two_nx/ny/nz, zero fill
   input  wire logic [IN_WIDTH-1:0]                  req_tdata,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   // out_x, out_y, out_z
   output logic [3*ssee_pkg::OUT_BITS-1:0]           rsp_tdata,
   output logic                                      rsp_tlast,
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   input  wire logic                                 csr_psel,
   input  wire logic                                 csr_penable,
   input  wire logic                                 csr_pwrite,
   input  wire logic [ADDR_BITS-1:0]                 csr_paddr,
   input  wire logic [CSR_BITS-1:0]                  csr_pwdata,
   output logic [CSR_BITS-1:0]                       csr_prdata,
   output logic                                      csr_pready
);
   import ssee_pkg::*;

   localparam int CB = COORD_BITS;
   localparam int NB = NORMAL_BITS;
   localparam int LW = CB + 2;
   localparam int DFW = CB + 1;
   localparam int PW = NB + LW;
   localparam int DW = PW + 2;
   localparam int EW = DFW + FACTOR_BITS + 1;
   localparam int XW = (EW + 1 > OUT_BITS + 1) ? EW + 1 : OUT_BITS + 1;

   // Configuration registers.
   logic signed [CB-1:0]    light_ff [3];
   logic [FACTOR_BITS-1:0]  factor_ff;
   logic                    csr_write;
   logic [1:0]              csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[ADDR_LSB +: 2];

   always_ff @(posedge clock) begin
      if (reset) begin
         light_ff[0] <= CB'(LIGHT_X_RESET);
         light_ff[1] <= CB'(LIGHT_Y_RESET);
         light_ff[2] <= CB'(LIGHT_Z_RESET);
         factor_ff   <= FACTOR_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_LIGHT_X: light_ff[0] <= csr_pwdata[CB-1:0];
            REG_LIGHT_Y: light_ff[1] <= csr_pwdata[CB-1:0];
            REG_LIGHT_Z: light_ff[2] <= csr_pwdata[CB-1:0];
            REG_FACTOR:  factor_ff   <= csr_pwdata[FACTOR_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_LIGHT_X: csr_prdata = CSR_BITS'(light_ff[0]);
         REG_LIGHT_Y: csr_prdata = CSR_BITS'(light_ff[1]);
         REG_LIGHT_Z: csr_prdata = CSR_BITS'(light_ff[2]);
         REG_FACTOR:  csr_prdata = CSR_BITS'(factor_ff);
         default:     csr_prdata = '0;
      endcase
   end

   function automatic vert_coord_type sat_out(input logic signed [XW-1:0] s);
      logic [XW-OUT_BITS:0] upper;
      upper = s[XW-1:OUT_BITS-1];
      if ((&upper) || !(|upper)) begin
         sat_out = s[OUT_BITS-1:0];
      end else if (s[XW-1]) begin
         sat_out = {1'b1, {(OUT_BITS-1){1'b0}}};
      end else begin
         sat_out = {1'b0, {(OUT_BITS-1){1'b1}}};
      end
   endfunction

   // Pipeline control.
   logic s1_v_ff, s2_v_ff, s3_v_ff, q_v_ff;
   logic s1_ready, s2_ready, s3_ready, q_free, q_load, rsp_take;
   logic s3_d1_neg, s3_d1_pos, s3_d2_neg, s3_d2_pos, s3_sil;

   // Stage 1: unpacked edge, doubled light-to-midpoint vector, endpoint offsets.
   logic signed [CB-1:0]  s1_a_ff [3], s1_b_ff [3];
   logic signed [NB-1:0]  s1_n1_ff [3], s1_n2_ff [3];
   logic signed [LW-1:0]  s1_lv_ff [3], s1_lv_in [3];
   logic signed [DFW-1:0] s1_da_ff [3], s1_da_in [3], s1_db_ff [3], s1_db_in [3];
   logic signed [CB-1:0]  in_a [3], in_b [3];
   logic signed [NB-1:0]  in_n1 [3], in_n2 [3];

   // Stage 2: dot-product terms and extrusion products.
   logic signed [CB-1:0]  s2_a_ff [3], s2_b_ff [3];
   logic signed [PW-1:0]  s2_p1_ff [3], s2_p1_in [3], s2_p2_ff [3], s2_p2_in [3];
   logic signed [EW-1:0]  s2_ea_ff [3], s2_ea_in [3], s2_eb_ff [3], s2_eb_in [3];

   // Stage 3: dot sums and saturated extruded coordinates.
   logic signed [CB-1:0]  s3_a_ff [3], s3_b_ff [3];
   logic signed [DW-1:0]  s3_d1_ff, s3_d1_in, s3_d2_ff, s3_d2_in;
   vert_coord_type        s3_xa_ff [3], s3_xa_in [3], s3_xb_ff [3], s3_xb_in [3];

   // Output quad buffer.
   vert_coord_type        q_vert_ff [QUAD_VERTS][3];
   vert_coord_type        q_vert_in [QUAD_VERTS][3];
   logic [1:0]            q_cnt_ff;

   assign rsp_take   = rsp_tvalid && rsp_tready;
   assign q_free     = !q_v_ff || (rsp_take && rsp_tlast);
   assign s3_d1_neg  = s3_d1_ff[DW-1];
   assign s3_d1_pos  = !s3_d1_ff[DW-1] && (|s3_d1_ff);
   assign s3_d2_neg  = s3_d2_ff[DW-1];
   assign s3_d2_pos  = !s3_d2_ff[DW-1] && (|s3_d2_ff);
   assign s3_sil     = (s3_d1_neg && s3_d2_pos) || (s3_d1_pos && s3_d2_neg);
   assign q_load     = s3_v_ff && s3_sil && q_free;
   assign s3_ready   = !s3_v_ff || !s3_sil || q_free;
   assign s2_ready   = !s2_v_ff || s3_ready;
   assign s1_ready   = !s1_v_ff || s2_ready;
   assign req_tready = s1_ready;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         in_a[i]  = req_tdata[i*CB +: CB];
         in_b[i]  = req_tdata[(3+i)*CB +: CB];
         in_n1[i] = req_tdata[6*CB + i*NB +: NB];
         in_n2[i] = req_tdata[6*CB + (3+i)*NB +: NB];
         s1_lv_in[i] = LW'(in_a[i]) + LW'(in_b[i]) - (LW'(light_ff[i]) <<< 1);
         s1_da_in[i] = DFW'(in_a[i]) - DFW'(light_ff[i]);
         s1_db_in[i] = DFW'(in_b[i]) - DFW'(light_ff[i]);
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s2_p1_in[i] = PW'(s1_n1_ff[i]) * PW'(s1_lv_ff[i]);
         s2_p2_in[i] = PW'(s1_n2_ff[i]) * PW'(s1_lv_ff[i]);
         s2_ea_in[i] = EW'(s1_da_ff[i]) * EW'($signed({1'b0, factor_ff}));
         s2_eb_in[i] = EW'(s1_db_ff[i]) * EW'($signed({1'b0, factor_ff}));
      end
   end

   always_comb begin
      s3_d1_in = DW'(s2_p1_ff[0]) + DW'(s2_p1_ff[1]) + DW'(s2_p1_ff[2]);
      s3_d2_in = DW'(s2_p2_ff[0]) + DW'(s2_p2_ff[1]) + DW'(s2_p2_ff[2]);
      for (int i = 0; i < 3; i++) begin
         s3_xa_in[i] = sat_out(XW'(s2_ea_ff[i]) + XW'(s2_a_ff[i]));
         s3_xb_in[i] = sat_out(XW'(s2_eb_ff[i]) + XW'(s2_b_ff[i]));
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (s3_d1_neg) begin
            q_vert_in[0][i] = OUT_BITS'(s3_b_ff[i]);
            q_vert_in[1][i] = OUT_BITS'(s3_a_ff[i]);
            q_vert_in[2][i] = s3_xa_ff[i];
            q_vert_in[3][i] = s3_xb_ff[i];
         end else begin
            q_vert_in[0][i] = OUT_BITS'(s3_a_ff[i]);
            q_vert_in[1][i] = OUT_BITS'(s3_b_ff[i]);
            q_vert_in[2][i] = s3_xb_ff[i];
            q_vert_in[3][i] = s3_xa_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         s3_v_ff  <= 1'b0;
         q_v_ff   <= 1'b0;
         q_cnt_ff <= '0;
      end else begin
         if (s1_ready) begin
            s1_v_ff <= req_tvalid;
         end
         if (s2_ready) begin
            s2_v_ff <= s1_v_ff;
         end
         if (s3_ready) begin
            s3_v_ff <= s2_v_ff;
         end
         if (q_load) begin
            q_v_ff   <= 1'b1;
            q_cnt_ff <= '0;
         end else if (rsp_take) begin
            q_cnt_ff <= q_cnt_ff + 2'd1;
            if (rsp_tlast) begin
               q_v_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_a_ff  <= in_a;
         s1_b_ff  <= in_b;
         s1_n1_ff <= in_n1;
         s1_n2_ff <= in_n2;
         s1_lv_ff <= s1_lv_in;
         s1_da_ff <= s1_da_in;
         s1_db_ff <= s1_db_in;
      end
      if (s2_ready) begin
         s2_a_ff  <= s1_a_ff;
         s2_b_ff  <= s1_b_ff;
         s2_p1_ff <= s2_p1_in;
         s2_p2_ff <= s2_p2_in;
         s2_ea_ff <= s2_ea_in;
         s2_eb_ff <= s2_eb_in;
      end
      if (s3_ready) begin
         s3_a_ff  <= s2_a_ff;
         s3_b_ff  <= s2_b_ff;
         s3_d1_ff <= s3_d1_in;
         s3_d2_ff <= s3_d2_in;
         s3_xa_ff <= s3_xa_in;
         s3_xb_ff <= s3_xb_in;
      end
      if (q_load) begin
         q_vert_ff <= q_vert_in;
      end
   end

   assign rsp_tvalid = q_v_ff;
   assign rsp_tlast  = (q_cnt_ff == 2'(QUAD_VERTS - 1));
   assign rsp_tdata  = {q_vert_ff[q_cnt_ff][2], q_vert_ff[q_cnt_ff][1], q_vert_ff[q_cnt_ff][0]};

   // An empty buffer always starts the next quad at its first vertex.
   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      !q_v_ff |-> (q_cnt_ff == 2'd0))
      else $error("quad buffer empty with nonzero vertex count");

   a_quad_continues: assert property (@(posedge clock) disable iff (reset)
      (rsp_take && !rsp_tlast) |=> rsp_tvalid)
      else $error("quad ended before its fourth vertex");

   a_quad_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_take && rsp_tlast && !q_load) |=> !rsp_tvalid)
      else $error("quad buffer still valid after its last vertex");

   a_load_first: assert property (@(posedge clock) disable iff (reset)
      q_load |=> (rsp_tvalid && (q_cnt_ff == 2'd0)))
      else $error("loaded quad does not start at its first vertex");

endmodule

`default_nettype wire

>>> sim/tb_top.sv
// Self-checking testbench for the shadow silhouette edge extruder: edge stream, quad check, csr.
module tb_top;
   import ssee_pkg::*;

   localparam int IN_W = 6 * 32 + 6 * 16;
   localparam int CLK_PERIOD = 8;
   localparam longint OUT_HI = (longint'(1) << (OUT_BITS - 1)) - 1;
   localparam longint OUT_LO = -OUT_HI - 1;
   localparam logic [31:0] C_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] C_MIN = 32'h8000_0000;
   localparam logic [31:0] ONE = 32'h0001_0000;
   localparam logic [31:0] NEG_ONE = 32'hFFFF_0000;
   localparam logic [31:0] LY500 = 32'd32768000;
   localparam logic [15:0] N_MAX = 16'h7FFF;
   localparam logic [15:0] N_MIN = 16'h8000;
   localparam logic [15:0] N_NMAX = 16'h8001;
   localparam logic [15:0] N_ONE = 16'h4000;
   localparam logic [15:0] N_NEG = 16'hC000;

   typedef struct packed {
      logic [2:0][15:0] n2;
      logic [2:0][15:0] n1;
      logic [2:0][31:0] b;
      logic [2:0][31:0] a;
   } mesh_edge_type;

   typedef struct packed {
      logic        last;
      logic [47:0] z;
      logic [47:0] y;
      logic [47:0] x;
   } quad_vert_type;

   logic            clock;
   logic            reset = 1'b1;
   // a_x, a_y, a_z, b_x, b_y, b_z, face_one_nx/ny/nz, face_two_nx/ny/nz
   logic [IN_W-1:0] req_tdata = '0;
   logic            req_tvalid = 1'b0;
   logic            req_tready;
   // out_x, out_y, out_z
   logic [143:0]    rsp_tdata;
   logic            rsp_tlast;
   logic            rsp_tvalid;
   logic            rsp_tready = 1'b0;
   logic            csr_psel = 1'b0;
   logic            csr_penable = 1'b0;
   logic            csr_pwrite = 1'b0;
   logic [3:0]      csr_paddr = '0;
   logic [31:0]     csr_pwdata = '0;
   logic [31:0]     csr_prdata;
   logic            csr_pready;

   logic [31:0]     reg_shadow [4];
   quad_vert_type   pending_verts [$];
   int              error_count = 0;
   int              send_idle_pct = 0;
   int              rsp_stall_pct = 0;
   int              hold_left = 0;

   shadow_silhouette_edge_extruder_unit u_dut (
      .clock(clock),
      .reset(reset),
      .req_tdata(req_tdata),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   initial begin
      #(CLK_PERIOD * 400000);
      $display("CHECK FAILED");
      $finish;
   end

   task automatic report_mismatch(input string what, input logic [47:0] got,
                                  input logic [47:0] want);
      error_count++;
      if (error_count <= 200) begin
         $display("ERROR at %0t: %s got %h expected %h", $time, what, got, want);
      end
   endtask

   function automatic longint extrude_clamped(input longint v, input longint l,
                                              input longint k);
      longint p;
      p = (v - l) * k + v;
      if (p > OUT_HI) return OUT_HI;
      if (p < OUT_LO) return OUT_LO;
      return p;
   endfunction

   function automatic quad_vert_type vert_of(input longint x, input longint y,
                                             input longint z, input logic last);
      quad_vert_type v;
      v.x = x[47:0];
      v.y = y[47:0];
      v.z = z[47:0];
      v.last = last;
      return v;
   endfunction

   task automatic queue_vert(input quad_vert_type v);
      pending_verts = {pending_verts, v};
   endtask

   task automatic predict_quad(input mesh_edge_type e);
      longint lt [3];
      longint p1 [3];
      longint p2 [3];
      longint lv [3];
      longint d1, d2, k, t;
      d1 = 0;
      d2 = 0;
      k = longint'(reg_shadow[REG_FACTOR][15:0]);
      lt[0] = longint'($signed(reg_shadow[REG_LIGHT_X]));
      lt[1] = longint'($signed(reg_shadow[REG_LIGHT_Y]));
      lt[2] = longint'($signed(reg_shadow[REG_LIGHT_Z]));
      for (int i = 0; i < 3; i++) begin
         p1[i] = longint'($signed(e.a[i]));
         p2[i] = longint'($signed(e.b[i]));
         lv[i] = p1[i] + p2[i] - 2 * lt[i];
         d1 += longint'($signed(e.n1[i])) * lv[i];
         d2 += longint'($signed(e.n2[i])) * lv[i];
      end
      if (d1 == 0 || d2 == 0 || ((d1 < 0) == (d2 < 0))) return;
      if (d1 < 0) begin
         for (int i = 0; i < 3; i++) begin
            t = p1[i];
            p1[i] = p2[i];
            p2[i] = t;
         end
      end
      queue_vert(vert_of(p1[0], p1[1], p1[2], 1'b0));
      queue_vert(vert_of(p2[0], p2[1], p2[2], 1'b0));
      queue_vert(vert_of(extrude_clamped(p2[0], lt[0], k),
                         extrude_clamped(p2[1], lt[1], k),
                         extrude_clamped(p2[2], lt[2], k), 1'b0));
      queue_vert(vert_of(extrude_clamped(p1[0], lt[0], k),
                         extrude_clamped(p1[1], lt[1], k),
                         extrude_clamped(p1[2], lt[2], k), 1'b1));
   endtask

   always @(posedge clock) begin : check_words
      quad_vert_type got;
      quad_vert_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tlast, rsp_tdata};
         if (pending_verts.size() == 0) begin
            report_mismatch("word with none expected, x", got.x, 48'h0);
         end else begin
            want = pending_verts.pop_front();
            if (got.x !== want.x) report_mismatch("out_x", got.x, want.x);
            if (got.y !== want.y) report_mismatch("out_y", got.y, want.y);
            if (got.z !== want.z) report_mismatch("out_z", got.z, want.z);
            if (got.last !== want.last) report_mismatch("tlast", got.last, want.last);
         end
      end
   end

   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= (rsp_stall_pct == 0) || ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   task automatic send_edge(input mesh_edge_type e);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tdata <= e;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      predict_quad(e);
   endtask

   task automatic wait_quiet();
      req_tvalid <= 1'b0;
      while (pending_verts.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      reg_shadow[idx] = (idx == REG_FACTOR) ? {16'd0, value[15:0]} : value;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_read_check(input logic [1:0] idx);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= {idx, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== reg_shadow[idx]) begin
         report_mismatch("register readback", csr_prdata, reg_shadow[idx]);
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_config(input logic [31:0] lx, input logic [31:0] ly,
                             input logic [31:0] lz, input logic [15:0] factor);
      wait_quiet();
      csr_write(REG_LIGHT_X, lx);
      csr_write(REG_LIGHT_Y, ly);
      csr_write(REG_LIGHT_Z, lz);
      csr_write(REG_FACTOR, {16'd0, factor});
      for (int r = 0; r < 4; r++) csr_read_check(2'(r));
   endtask

   function automatic mesh_edge_type make_edge(
      input logic [31:0] ax, input logic [31:0] ay, input logic [31:0] az,
      input logic [31:0] bx, input logic [31:0] by, input logic [31:0] bz,
      input logic [15:0] n1x, input logic [15:0] n1y, input logic [15:0] n1z,
      input logic [15:0] n2x, input logic [15:0] n2y, input logic [15:0] n2z);
      mesh_edge_type e;
      e.a = {az, ay, ax};
      e.b = {bz, by, bx};
      e.n1 = {n1z, n1y, n1x};
      e.n2 = {n2z, n2y, n2x};
      return e;
   endfunction

   function automatic logic [31:0] rand_coord();
      if ($urandom_range(3) == 0) return $urandom;
      return 32'($urandom_range(2097152)) - 32'd1048576;
   endfunction

   // Mostly boundary edges and unrelated normals; a few flat or degenerate ones.
   function automatic mesh_edge_type random_edge(input bit boundary_only);
      mesh_edge_type e;
      int kind;
      kind = boundary_only ? 0 : $urandom_range(9);
      for (int i = 0; i < 3; i++) begin
         e.a[i] = rand_coord();
         e.b[i] = rand_coord();
         e.n1[i] = 16'($urandom);
         e.n2[i] = 16'($urandom);
      end
      case (kind)
         0, 1, 2, 3, 4: begin
            for (int i = 0; i < 3; i++) e.n2[i] = -e.n1[i];
         end
         8: begin
            e.n2 = e.n1;
         end
         9: begin
            if ($urandom_range(1) == 0) e.n1 = '0;
            else e.n2 = '0;
         end
         default: begin
         end
      endcase
      return e;
   endfunction

   task automatic test_register_reset();
      for (int r = 0; r < 4; r++) csr_read_check(2'(r));
   endtask

   task automatic test_directed_edges();
      // Default light at (0, 500, 0), edge along x below it.
      send_edge(make_edge(ONE, 0, 0, NEG_ONE, 0, 0, 0, N_ONE, 0, 0, N_NEG, 0));
      send_edge(make_edge(ONE, 0, 0, NEG_ONE, 0, 0, 0, N_NEG, 0, 0, N_ONE, 0));
      send_edge(make_edge(ONE, 0, 0, NEG_ONE, 0, 0, 0, N_ONE, 0, 0, N_ONE, 0));
      send_edge(make_edge(ONE, 0, 0, NEG_ONE, 0, 0, 0, 0, 0, 0, N_ONE, 0));
      send_edge(make_edge(ONE, 0, 0, NEG_ONE, 0, 0, 0, 0, 0, 0, 0, 0));
      send_edge(make_edge(0, LY500, 0, 0, LY500, 0, 0, N_ONE, 0, 0, N_NEG, 0));
      send_edge(make_edge(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN,
                          N_MIN, N_MIN, N_MIN, N_MIN, N_MIN, N_MIN));
      send_edge(make_edge(C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN,
                          N_MAX, N_MIN, N_MAX, N_MIN, N_MAX, N_MIN));
      send_edge(make_edge(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX,
                          N_MAX, N_MAX, N_MAX, N_NMAX, N_NMAX, N_NMAX));
      set_config(C_MIN, C_MIN, C_MIN, 16'hFFFF);
      send_edge(make_edge(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX,
                          N_MAX, N_MAX, N_MAX, N_NMAX, N_NMAX, N_NMAX));
      send_edge(make_edge(C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN,
                          N_ONE, N_ONE, N_ONE, N_NEG, N_NEG, N_NEG));
      set_config(C_MAX, C_MAX, C_MAX, 16'hFFFF);
      send_edge(make_edge(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN,
                          N_ONE, N_ONE, N_ONE, N_NEG, N_NEG, N_NEG));
      set_config(ONE, NEG_ONE, 32'd0, 16'd0);
      repeat (3) send_edge(random_edge(1'b1));
      set_config(32'd0, LY500, 32'd0, 16'd1);
      repeat (3) send_edge(random_edge(1'b1));
   endtask

   task automatic test_random_traffic();
      int send_pct [4];
      int stall_pct [4];
      logic [15:0] factor;
      send_pct = '{0, 65, 0, 35};
      stall_pct = '{0, 0, 65, 35};
      for (int p = 0; p < 4; p++) begin
         case ($urandom_range(3))
            0: factor = 16'd0;
            1: factor = 16'hFFFF;
            2: factor = 16'($urandom_range(255));
            default: factor = 16'($urandom);
         endcase
         set_config(rand_coord(), rand_coord(), rand_coord(), factor);
         send_idle_pct = send_pct[p];
         rsp_stall_pct = stall_pct[p];
         repeat (48) send_edge(random_edge(1'b0));
      end
      wait_quiet();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      hold_left = 300;
      repeat (20) send_edge(random_edge(1'b1));
      wait_quiet();
   endtask

   initial begin
      reg_shadow[REG_LIGHT_X] = 32'(LIGHT_X_RESET);
      reg_shadow[REG_LIGHT_Y] = 32'(LIGHT_Y_RESET);
      reg_shadow[REG_LIGHT_Z] = 32'(LIGHT_Z_RESET);
      reg_shadow[REG_FACTOR] = {16'd0, FACTOR_RESET};
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_register_reset();
      test_directed_edges();
      test_random_traffic();
      test_backpressure();
      wait_quiet();
      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule

>>> files.f
sv/ssee_pkg.sv
sv/shadow_silhouette_edge_extruder_unit.sv
sim/tb_top.sv
